// ===== hw/rtl/button_click_hold_stuck_detector_assert.svh =====
// ----------------------------------------------------------------------------
// Button click/hold/stuck detector: assertion macros
// Shorthand for the concurrent checks of the detector checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_STUCK_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_HOLD_STUCK_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BCHSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bchsd check failed");

// Next-cycle implication, disabled while reset is high.
`define BCHSD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bchsd check failed");

`endif

// ===== hw/rtl/bchsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Button click/hold/stuck detector package
// Shared widths, codes and register reset values of the detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bchsd_pkg;

  // Default width of timestamps and durations.
  localparam int unsigned TIME_WIDTH_DEF = 48;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = 24'd655;
  localparam logic [CFG_DATA_W-1:0] HOLD_RST     = 24'd32768;
  localparam logic [CFG_DATA_W-1:0] STUCK_RST    = 24'd327680;

  // Item kinds.
  localparam logic FUNC_LEVEL = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_STUCK    = 2'd2,
    CFG_INVERT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_RELEASED  = 2'd0,
    ST_PRESSED   = 2'd1,
    ST_UNPRESSED = 2'd2
  } st_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_RELEASE = 3'd1,
    EV_CLICK   = 3'd2,
    EV_HOLD    = 3'd3,
    EV_STUCK   = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    CLS_RELEASED = 2'd0,
    CLS_CLICK    = 2'd1,
    CLS_HOLD     = 2'd2,
    CLS_STUCK    = 2'd3
  } cls_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bchsd_in_if.sv =====
// ----------------------------------------------------------------------------
// Detector input channel
// Valid/ready channel carrying one contact change or tick item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bchsd_in_if #(
  parameter int unsigned TIME_WIDTH = bchsd_pkg::TIME_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic                  contact_level;
  logic [TIME_WIDTH-1:0] now_time;

  modport source (output valid, output func, output contact_level, output now_time,
                  input ready);
  modport sink   (input valid, input func, input contact_level, input now_time,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bchsd_out_if.sv =====
// ----------------------------------------------------------------------------
// Detector result channel
// Valid/ready channel carrying one classification result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bchsd_out_if #(
  parameter int unsigned TIME_WIDTH = bchsd_pkg::TIME_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            event_res;
  logic [TIME_WIDTH-1:0] event_duration;
  logic [1:0]            current_class;
  logic [TIME_WIDTH-1:0] held_duration;
  logic                  protocol_error;

  modport source (output valid, output event_res, output event_duration,
                  output current_class, output held_duration, output protocol_error,
                  input ready);
  modport sink   (input valid, input event_res, input event_duration,
                  input current_class, input held_duration, input protocol_error,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/button_click_hold_stuck_detector.sv =====
// ----------------------------------------------------------------------------
// Button click/hold/stuck detector
// Classifies a push button from timestamped contact changes and time ticks.
//
// Usage:
// - in_ch takes one item per handshake: a contact level change (func 0) or a
//   plain tick (func 1), each with the current uptime in now_time.
// - out_ch returns exactly one result item per input item, in order.
// - cfg_we/cfg_index/cfg_data write the debounce, hold and stuck thresholds
//   and the level inversion; writes that break the threshold rules are
//   dropped. Write only while no item is in flight.
// - An accepted item passes through the input register and then moves to the
//   result register, which drives result valid.
//   Throughput is one item per cycle while the receiver does not stall; the
//   state update between the two registers is combinational, which sets that rate.
// - When the receiver stalls, the result register holds its item and the
//   input register can still take one more item; then in_ch.ready drops.
// - Synchronous reset empties both registers, returns the button to the
//   released state, disarms the deadline and restores default thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_click_hold_stuck_detector #(
  parameter int unsigned TIME_WIDTH = bchsd_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bchsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bchsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  bchsd_in_if.sink                                 in_ch,
  bchsd_out_if.source                              out_ch
);
  import bchsd_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] debounce_ticks;
  logic [CFG_DATA_W-1:0] hold_ticks;
  logic [CFG_DATA_W-1:0] stuck_ticks;
  logic                  invert_level;

  // Input register.
  logic                  s1_valid;
  logic                  s1_func;
  logic                  s1_level;
  logic [TIME_WIDTH-1:0] s1_now;
  logic                  s1_go;

  // Button state.
  st_t                   main_state,     main_state_next;
  logic                  hold_flag,      hold_flag_next;
  logic                  stuck_flag,     stuck_flag_next;
  logic [TIME_WIDTH-1:0] press_time,     press_time_next;
  logic                  alarm_armed,    alarm_armed_next;
  logic [TIME_WIDTH-1:0] alarm_deadline, alarm_deadline_next;

  // Result register.
  logic                  out_valid;
  ev_t                   event_res,      event_res_next;
  logic [TIME_WIDTH-1:0] event_duration, event_duration_next;
  cls_t                  current_class,  current_class_next;
  logic [TIME_WIDTH-1:0] held_duration,  held_duration_next;
  logic                  protocol_error, protocol_error_next;

  // Shared decode of the item in the input register.
  logic                  pressed;
  logic [TIME_WIDTH-1:0] since_press;
  logic                  prom_hold;
  logic                  prom_stuck;
  logic                  alarm_fire;

  assign pressed     = s1_level ^ invert_level;
  assign since_press = s1_now - press_time;
  assign prom_hold   = !stuck_flag && !hold_flag && (TIME_WIDTH'(hold_ticks) <= since_press);
  assign prom_stuck  = !stuck_flag && hold_flag && (TIME_WIDTH'(stuck_ticks) <= since_press);
  assign alarm_fire  = (s1_func == FUNC_TICK) && alarm_armed && (s1_now >= alarm_deadline);

  // Handshakes: the input register moves on when the result register is free.
  assign s1_go       = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_go;

  // Configuration writes, with the threshold ordering rules enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RST;
      hold_ticks     <= HOLD_RST;
      stuck_ticks    <= STUCK_RST;
      invert_level   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: begin
          if (cfg_data != '0) debounce_ticks <= cfg_data;
        end
        CFG_HOLD: begin
          if (cfg_data != '0 && cfg_data <= stuck_ticks) hold_ticks <= cfg_data;
        end
        CFG_STUCK: begin
          if (cfg_data != '0 && cfg_data >= hold_ticks) stuck_ticks <= cfg_data;
        end
        CFG_INVERT: begin
          invert_level <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_func  <= in_ch.func;
      s1_level <= in_ch.contact_level;
      s1_now   <= in_ch.now_time;
    end
  end

  // Next button state and alarm deadline.
  always_comb begin
    logic [CFG_DATA_W-1:0] rearm_ticks;
    rearm_ticks         = hold_ticks;
    main_state_next     = main_state;
    hold_flag_next      = hold_flag;
    stuck_flag_next     = stuck_flag;
    press_time_next     = press_time;
    alarm_armed_next    = alarm_armed;
    alarm_deadline_next = alarm_deadline;
    if (s1_func == FUNC_LEVEL) begin
      alarm_armed_next = 1'b0;
      case (main_state)
        ST_PRESSED: begin
          // Release (or a contradicting press treated as one): start debounce.
          main_state_next     = ST_UNPRESSED;
          alarm_armed_next    = 1'b1;
          alarm_deadline_next = s1_now + TIME_WIDTH'(debounce_ticks);
        end
        ST_UNPRESSED: begin
          // Bounce back to pressed, promoting by the time held so far.
          main_state_next = ST_PRESSED;
          if (prom_hold)  hold_flag_next  = 1'b1;
          if (prom_stuck) stuck_flag_next = 1'b1;
        end
        default: begin
          // Fresh press from released.
          if (pressed) begin
            main_state_next = ST_PRESSED;
            hold_flag_next  = 1'b0;
            stuck_flag_next = 1'b0;
            press_time_next = s1_now;
          end
        end
      endcase
      // While held below the stuck class, wait for the next threshold.
      rearm_ticks = hold_flag_next ? stuck_ticks : hold_ticks;
      if (main_state_next == ST_PRESSED && !stuck_flag_next) begin
        alarm_armed_next    = 1'b1;
        alarm_deadline_next = press_time_next + TIME_WIDTH'(rearm_ticks);
      end
    end else if (alarm_fire) begin
      alarm_armed_next = 1'b0;
      case (main_state)
        ST_UNPRESSED: begin
          main_state_next = ST_RELEASED;
          hold_flag_next  = 1'b0;
          stuck_flag_next = 1'b0;
        end
        ST_PRESSED: begin
          if (hold_flag) begin
            stuck_flag_next = 1'b1;
          end else begin
            hold_flag_next      = 1'b1;
            alarm_armed_next    = 1'b1;
            alarm_deadline_next = press_time + TIME_WIDTH'(stuck_ticks);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields for the item in the input register.
  always_comb begin
    event_res_next      = EV_NONE;
    event_duration_next = '0;
    protocol_error_next = 1'b0;
    if (s1_func == FUNC_LEVEL) begin
      case (main_state)
        ST_PRESSED: begin
          protocol_error_next = pressed;
        end
        ST_UNPRESSED: begin
          protocol_error_next = !pressed;
          if (prom_hold) begin
            event_res_next      = EV_HOLD;
            event_duration_next = since_press;
          end else if (prom_stuck) begin
            event_res_next      = EV_STUCK;
            event_duration_next = since_press;
          end
        end
        default: begin
          protocol_error_next = !pressed;
          if (pressed) event_res_next = EV_CLICK;
        end
      endcase
    end else if (alarm_fire) begin
      case (main_state)
        ST_UNPRESSED: begin
          event_res_next      = EV_RELEASE;
          event_duration_next = since_press;
        end
        ST_PRESSED: begin
          event_res_next      = hold_flag ? EV_STUCK : EV_HOLD;
          event_duration_next = since_press;
        end
        default: begin
        end
      endcase
    end

    // Class after this item.
    if (stuck_flag_next) begin
      current_class_next = CLS_STUCK;
    end else if (hold_flag_next) begin
      current_class_next = CLS_HOLD;
    end else if (main_state_next == ST_PRESSED || main_state_next == ST_UNPRESSED) begin
      current_class_next = CLS_CLICK;
    end else begin
      current_class_next = CLS_RELEASED;
    end
    held_duration_next = (current_class_next == CLS_RELEASED) ? '0 :
                         (s1_now - press_time_next);
  end

  // Button state registers, updated as an item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_state     <= ST_RELEASED;
      hold_flag      <= 1'b0;
      stuck_flag     <= 1'b0;
      press_time     <= '0;
      alarm_armed    <= 1'b0;
      alarm_deadline <= '0;
    end else if (s1_go) begin
      main_state     <= main_state_next;
      hold_flag      <= hold_flag_next;
      stuck_flag     <= stuck_flag_next;
      press_time     <= press_time_next;
      alarm_armed    <= alarm_armed_next;
      alarm_deadline <= alarm_deadline_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      event_res      <= event_res_next;
      event_duration <= event_duration_next;
      current_class  <= current_class_next;
      held_duration  <= held_duration_next;
      protocol_error <= protocol_error_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.event_res      = event_res;
  assign out_ch.event_duration = event_duration;
  assign out_ch.current_class  = current_class;
  assign out_ch.held_duration  = held_duration;
  assign out_ch.protocol_error = protocol_error;

endmodule

`default_nettype wire

// ===== hw/rtl/bchsd_checker.sv =====
// ----------------------------------------------------------------------------
// Button click/hold/stuck detector checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "button_click_hold_stuck_detector_assert.svh"

module bchsd_checker #(
  parameter int unsigned TIME_WIDTH = bchsd_pkg::TIME_WIDTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [2:0]            event_res,
  input wire logic [TIME_WIDTH-1:0] event_duration,
  input wire logic [1:0]            current_class,
  input wire logic [TIME_WIDTH-1:0] held_duration,
  input wire logic                  protocol_error
);
  import bchsd_pkg::*;

  // A stalled result item stays put.
  `BCHSD_ASSERT_NXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(event_duration) && $stable(held_duration) && $stable(current_class) && $stable(protocol_error))

  // A click starts a fresh press: no duration yet, class is click.
  `BCHSD_ASSERT_IMP(a_click_fresh, clk, rst, out_valid && event_res == EV_CLICK, current_class == CLS_CLICK && held_duration == '0 && event_duration == '0)

  // A confirmed release leaves the button released with nothing held.
  `BCHSD_ASSERT_IMP(a_release_clears, clk, rst, out_valid && event_res == EV_RELEASE, current_class == CLS_RELEASED && held_duration == '0)

  // Releases come only from ticks, which never flag an ordering error.
  `BCHSD_ASSERT_IMP(a_err_no_release, clk, rst, out_valid && protocol_error, event_res != EV_RELEASE)

endmodule

bind button_click_hold_stuck_detector bchsd_checker #(
  .TIME_WIDTH(TIME_WIDTH)
) u_bchsd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .event_res      (out_ch.event_res),
  .event_duration (out_ch.event_duration),
  .current_class  (out_ch.current_class),
  .held_duration  (out_ch.held_duration),
  .protocol_error (out_ch.protocol_error)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Button click/hold/stuck detector testbench
// Drives contact changes and ticks through the valid/ready input channel and
// checks every result item against a cycle-free model of the detector. Runs
// directed corner cases, several threshold settings with random press
// sessions, long random traffic and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bchsd_pkg::*;

  localparam int unsigned TW             = TIME_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned HOLDOFF_CYCLES = 150;
  localparam int unsigned PRINT_CAP      = 100;
  localparam logic [TW-1:0] MAX_TIME     = '1;

  // One result item as the detector reports it.
  typedef struct packed {
    ev_t           ev;
    logic [TW-1:0] dur;
    cls_t          cls;
    logic [TW-1:0] held;
    logic          err;
  } button_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bchsd_in_if  #(.TIME_WIDTH(TW)) in_ch ();
  bchsd_out_if #(.TIME_WIDTH(TW)) out_ch ();

  button_click_hold_stuck_detector #(.TIME_WIDTH(TW)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Clock.
  always #10 clk = ~clk;

  // Model of the detector: thresholds and button state.
  logic [CFG_DATA_W-1:0] debounce_len = DEBOUNCE_RST;
  logic [CFG_DATA_W-1:0] hold_len     = HOLD_RST;
  logic [CFG_DATA_W-1:0] stuck_len    = STUCK_RST;
  logic                  invert_bit   = 1'b0;
  st_t                   btn_state    = ST_RELEASED;
  logic                  hold_seen    = 1'b0;
  logic                  stuck_seen   = 1'b0;
  logic [TW-1:0]         press_at     = '0;
  logic                  deadline_armed = 1'b0;
  logic [TW-1:0]         deadline_at  = '0;

  button_result_t expected_results[$];

  // Stimulus and run control.
  logic [TW-1:0] uptime = '0;
  logic          contact_down = 1'b0;
  bit            gaps_on = 1'b1;
  logic          holdoff_req = 1'b0;
  logic          rx_blocked;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  function automatic void arm_deadline(input logic [TW-1:0] at);
    deadline_armed = 1'b1;
    deadline_at    = at;
  endfunction

  function automatic cls_t button_class();
    if (stuck_seen) return CLS_STUCK;
    if (hold_seen) return CLS_HOLD;
    if (btn_state == ST_PRESSED || btn_state == ST_UNPRESSED) return CLS_CLICK;
    return CLS_RELEASED;
  endfunction

  // Advance the model by one item and return the result it must produce.
  function automatic button_result_t classify_item(input logic kind, input logic level,
                                                   input logic [TW-1:0] now);
    button_result_t r;
    logic           pressed;
    logic [TW-1:0]  since_press;
    r.ev  = EV_NONE;
    r.dur = '0;
    r.err = 1'b0;
    pressed     = level ^ invert_bit;
    since_press = now - press_at;
    if (kind == FUNC_LEVEL) begin
      // Every contact change drops the pending deadline first.
      deadline_armed = 1'b0;
      if (btn_state == ST_PRESSED) begin
        // A press here is out of order and still counts as a release.
        r.err     = pressed;
        btn_state = ST_UNPRESSED;
        arm_deadline(now + debounce_len);
      end else if (btn_state == ST_UNPRESSED) begin
        // A release here is out of order and still counts as a press.
        r.err     = !pressed;
        btn_state = ST_PRESSED;
        if (stuck_seen) begin
          r.ev = EV_NONE;
        end else if (hold_seen) begin
          if (since_press >= stuck_len) begin
            stuck_seen = 1'b1;
            r.ev       = EV_STUCK;
            r.dur      = since_press;
          end
        end else if (since_press >= hold_len) begin
          hold_seen = 1'b1;
          r.ev      = EV_HOLD;
          r.dur     = since_press;
        end
      end else begin
        if (!pressed) begin
          r.err = 1'b1;
        end else begin
          btn_state  = ST_PRESSED;
          hold_seen  = 1'b0;
          stuck_seen = 1'b0;
          press_at   = now;
          r.ev       = EV_CLICK;
        end
      end
      if (btn_state == ST_PRESSED && !stuck_seen) begin
        arm_deadline(press_at + (hold_seen ? stuck_len : hold_len));
      end
    end else if (deadline_armed && now >= deadline_at) begin
      deadline_armed = 1'b0;
      if (btn_state == ST_UNPRESSED) begin
        btn_state  = ST_RELEASED;
        hold_seen  = 1'b0;
        stuck_seen = 1'b0;
        r.ev       = EV_RELEASE;
        r.dur      = since_press;
      end else if (btn_state == ST_PRESSED) begin
        if (hold_seen) begin
          stuck_seen = 1'b1;
          r.ev       = EV_STUCK;
          r.dur      = since_press;
        end else begin
          hold_seen = 1'b1;
          r.ev      = EV_HOLD;
          r.dur     = since_press;
          arm_deadline(press_at + stuck_len);
        end
      end
    end
    r.cls  = button_class();
    r.held = (r.cls == CLS_RELEASED) ? '0 : (now - press_at);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    end
  endtask

  // Compare one accepted result item with the oldest expectation.
  task automatic check_result();
    button_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result item with none expected", 64'(out_ch.event_res), 64'd0);
      return;
    end
    want = expected_results.pop_front();
    if (out_ch.event_res !== want.ev)
      report_mismatch("event_res", 64'(out_ch.event_res), 64'(want.ev));
    if (out_ch.event_duration !== want.dur)
      report_mismatch("event_duration", 64'(out_ch.event_duration), 64'(want.dur));
    if (out_ch.current_class !== want.cls)
      report_mismatch("current_class", 64'(out_ch.current_class), 64'(want.cls));
    if (out_ch.held_duration !== want.held)
      report_mismatch("held_duration", 64'(out_ch.held_duration), 64'(want.held));
    if (out_ch.protocol_error !== want.err)
      report_mismatch("protocol_error", 64'(out_ch.protocol_error), 64'(want.err));
  endtask

  // Offer one item, wait for the handshake, then record what must come back.
  task automatic send_item(input logic kind, input logic level, input logic [TW-1:0] now);
    while (gaps_on && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= kind;
    in_ch.contact_level <= level;
    in_ch.now_time      <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(classify_item(kind, level, now));
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    // Writes that break the threshold ordering are dropped by the block.
    case (idx)
      CFG_DEBOUNCE: if (value >= 1) debounce_len = value;
      CFG_HOLD:     if (value >= 1 && value <= stuck_len) hold_len = value;
      CFG_STUCK:    if (value >= 1 && value >= hold_len) stuck_len = value;
      default:      invert_bit = value[0];
    endcase
    @(posedge clk);
  endtask

  // Time advance scaled to the current thresholds so all deadlines get hit.
  function automatic logic [TW-1:0] random_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return TW'($urandom_range(0, debounce_len + 2));
      4, 5, 6:    return TW'($urandom_range(0, hold_len / 2 + 2));
      7, 8:       return TW'($urandom_range(0, stuck_len / 3 + 2));
      default:    return TW'($urandom_range(0, 3));
    endcase
  endfunction

  // Random press sessions: mostly alternating contact changes and ticks,
  // with some out-of-order levels and wild or backward time jumps.
  task automatic run_sessions(input int unsigned count);
    int unsigned   roll;
    logic [63:0]   wide;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        wide   = {$urandom, $urandom};
        uptime = wide[TW-1:0];
        send_item(FUNC_TICK, 1'($urandom_range(0, 1)), uptime);
      end else if (roll < 7) begin
        uptime = uptime - TW'($urandom_range(0, debounce_len));
        send_item(FUNC_TICK, 1'($urandom_range(0, 1)), uptime);
      end else if (roll < 12) begin
        contact_down = 1'($urandom_range(0, 1));
        uptime       = uptime + random_step();
        send_item(FUNC_LEVEL, contact_down ^ invert_bit, uptime);
      end else if (roll < 45) begin
        contact_down = !contact_down;
        uptime       = uptime + random_step();
        send_item(FUNC_LEVEL, contact_down ^ invert_bit, uptime);
      end else begin
        uptime = uptime + random_step();
        send_item(FUNC_TICK, 1'($urandom_range(0, 1)), uptime);
      end
    end
  endtask

  // Reset thresholds, no register writes yet.
  task automatic test_default_thresholds();
    run_sessions(150);
  endtask

  // Protocol errors, deadline expiry, hold and stuck, wrapping deadlines and
  // the inverted contact level.
  task automatic test_special_cases();
    // Bring the button back to released before the fixed timeline.
    if (btn_state == ST_PRESSED) send_item(FUNC_LEVEL, invert_bit, uptime + 1);
    if (btn_state == ST_UNPRESSED) send_item(FUNC_TICK, 1'b0, deadline_at);
    write_reg(CFG_INVERT, 24'd0);
    write_reg(CFG_DEBOUNCE, 24'd5);
    write_reg(CFG_HOLD, 24'd20);
    write_reg(CFG_STUCK, 24'd50);
    send_item(FUNC_LEVEL, 1'b0, 48'd100);      // release while released
    send_item(FUNC_LEVEL, 1'b1, 48'd110);      // click
    send_item(FUNC_LEVEL, 1'b1, 48'd112);      // press while pressed
    send_item(FUNC_TICK,  1'b0, 48'd116);      // before the debounce deadline
    send_item(FUNC_LEVEL, 1'b0, 48'd116);      // release while unpressed
    send_item(FUNC_LEVEL, 1'b0, 48'd118);
    send_item(FUNC_TICK,  1'b1, 48'd123);      // release confirmed
    send_item(FUNC_LEVEL, 1'b1, 48'd200);
    send_item(FUNC_TICK,  1'b0, 48'd220);      // hold by deadline
    send_item(FUNC_LEVEL, 1'b0, 48'd230);
    send_item(FUNC_LEVEL, 1'b1, 48'd232);      // bounce while in hold
    send_item(FUNC_TICK,  1'b0, 48'd250);      // stuck by deadline
    send_item(FUNC_LEVEL, 1'b0, 48'd260);
    send_item(FUNC_LEVEL, 1'b1, 48'd262);      // bounce while stuck
    send_item(FUNC_TICK,  1'b0, 48'd400);      // no deadline pending
    send_item(FUNC_LEVEL, 1'b0, 48'd500);
    send_item(FUNC_TICK,  1'b0, 48'd505);
    // Deadlines that wrap past the top of the time range.
    send_item(FUNC_LEVEL, 1'b1, MAX_TIME - 9);
    send_item(FUNC_TICK,  1'b1, MAX_TIME - 8);
    send_item(FUNC_TICK,  1'b0, 48'd0);
    send_item(FUNC_LEVEL, 1'b0, MAX_TIME);
    send_item(FUNC_TICK,  1'b0, 48'd5);
    // Active-low contact.
    write_reg(CFG_INVERT, 24'd1);
    send_item(FUNC_LEVEL, 1'b0, 48'd700);
    send_item(FUNC_LEVEL, 1'b1, 48'd701);
    send_item(FUNC_TICK,  1'b0, 48'd706);
    uptime       = 48'd1000;
    contact_down = 1'b0;
  endtask

  // Extreme and rejected register values, each followed by random sessions.
  task automatic test_threshold_settings();
    logic [CFG_DATA_W-1:0] val;
    // Smallest thresholds; a zero debounce is refused.
    write_reg(CFG_DEBOUNCE, 24'd0);
    write_reg(CFG_DEBOUNCE, 24'd1);
    write_reg(CFG_HOLD, 24'd1);
    write_reg(CFG_STUCK, 24'd1);
    write_reg(CFG_INVERT, 24'hFFFFFE);
    run_sessions(60);
    // Largest thresholds.
    write_reg(CFG_STUCK, 24'hFFFFFF);
    write_reg(CFG_HOLD, 24'hFFFFFF);
    write_reg(CFG_DEBOUNCE, 24'hFFFFFF);
    write_reg(CFG_INVERT, 24'd1);
    run_sessions(60);
    // Out-of-order thresholds are refused.
    write_reg(CFG_HOLD, 24'd0);
    write_reg(CFG_STUCK, 24'd100);
    write_reg(CFG_HOLD, 24'd10);
    write_reg(CFG_STUCK, 24'd100);
    write_reg(CFG_STUCK, 24'd5);
    write_reg(CFG_HOLD, 24'd200);
    write_reg(CFG_DEBOUNCE, 24'd3);
    write_reg(CFG_INVERT, 24'hFFFFFF);
    run_sessions(60);
    // Random legal settings.
    repeat (3) begin
      val = CFG_DATA_W'($urandom_range(1, 20000));
      write_reg(CFG_STUCK, 24'hFFFFFF);
      write_reg(CFG_HOLD, val);
      write_reg(CFG_STUCK, val + CFG_DATA_W'($urandom_range(0, 100000)));
      write_reg(CFG_DEBOUNCE, CFG_DATA_W'($urandom_range(1, 4000)));
      write_reg(CFG_INVERT, CFG_DATA_W'($urandom));
      run_sessions(60);
    end
  endtask

  // Long random traffic; one phase runs without any idle cycles.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] val;
    for (int phase = 0; phase < 4; phase++) begin
      val = CFG_DATA_W'($urandom_range(1, 3000));
      write_reg(CFG_STUCK, 24'hFFFFFF);
      write_reg(CFG_HOLD, val);
      write_reg(CFG_STUCK, val + CFG_DATA_W'($urandom_range(0, 30000)));
      write_reg(CFG_DEBOUNCE, CFG_DATA_W'($urandom_range(1, 500)));
      write_reg(CFG_INVERT, CFG_DATA_W'($urandom_range(0, 1)));
      gaps_on = (phase != 2);
      run_sessions(300);
      gaps_on = 1'b1;
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_backpressure();
    wait_idle();
    gaps_on     = 1'b0;
    holdoff_req <= 1'b1;
    run_sessions(40);
    gaps_on = 1'b1;
  endtask

  // Main sequence.
  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_DEBOUNCE;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_LEVEL;
    in_ch.contact_level <= 1'b0;
    in_ch.now_time      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_thresholds();
    test_special_cases();
    test_threshold_settings();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result receiver: random stalls, plus the long hold-off when asked.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready) check_result();
      out_ch.ready <= !rx_blocked && !(gaps_on && $urandom_range(0, 99) < 15);
    end
  end

  // Hold-off counter for the receiver.
  initial begin
    rx_blocked <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req <= 1'b0;
        rx_blocked  <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        rx_blocked <= 1'b0;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bchsd_pkg.sv
hw/rtl/bchsd_in_if.sv
hw/rtl/bchsd_out_if.sv
hw/rtl/button_click_hold_stuck_detector.sv
hw/rtl/bchsd_checker.sv
tb/testbench.sv
